FILE: design/radix_text_to_integer_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the text to integer parser
// Shared forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef RADIX_TEXT_TO_INTEGER_TOP_MACROS_SVH
`define RADIX_TEXT_TO_INTEGER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RTI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RTI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg
// Types and constants shared by the text to integer parser.
// ----------------------------------------------------------------------------
package rti_pkg;

    localparam int RADIX_W      = 6;
    localparam int CFG_IDX_BITS = 1;
    localparam int Q_DEPTH      = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_RADIX  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DECODE = 1'd1;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_OCT   = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX   = 6'd16;
    localparam logic [RADIX_W-1:0] NOT_DIGIT   = 6'h3F;
    localparam logic [RADIX_W-1:0] LETTER_BIAS = 6'd9;

    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_HASH     = 8'h23;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CH_LOWER_X  = 8'h78;
    localparam logic [7:0] CH_UPPER_X  = 8'h58;
    localparam logic [7:0] LETTER_MASK = 8'h1F;

    typedef struct packed {
        logic [RADIX_W-1:0] val;
        logic               is_minus;
        logic               is_plus;
        logic               is_hash;
        logic               is_zero;
        logic               is_x;
        logic               last;
    } t_cls;

endpackage

FILE: design/rti_in_if.sv
// ----------------------------------------------------------------------------
// rti_in_if
// Character channel: one text byte per transfer with a last flag.
// ----------------------------------------------------------------------------
interface rti_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink (input valid, input ch, input last, output ready);
endinterface

FILE: design/rti_out_if.sv
// ----------------------------------------------------------------------------
// rti_out_if
// Result channel: parsed signed value and error flag per transfer.
// ----------------------------------------------------------------------------
interface rti_out_if #(
    parameter int WORD_BITS = 32
);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] value;
    logic                        error;

    modport source (output valid, output value, output error, input ready);
    modport sink (input valid, input value, input error, output ready);
endinterface

FILE: design/rti_front.sv
// ----------------------------------------------------------------------------
// rti_front
// Accepts characters and classifies each into a digit value and symbol flags.
// ----------------------------------------------------------------------------
module rti_front (
    rti_in_if.sink        i_in,
    input  logic          i_q_ready,
    output logic          o_push,
    output rti_pkg::t_cls o_cls
);
    import rti_pkg::*;

    logic [7:0] ch;

    assign ch         = i_in.ch;
    assign i_in.ready = i_q_ready;
    assign o_push     = i_in.valid & i_q_ready;

    always_comb begin
        if (ch inside {[CH_ZERO:CH_NINE]}) begin
            o_cls.val = RADIX_W'(ch - CH_ZERO);
        end else if (ch inside {[CH_LOWER_A:CH_LOWER_Z], [CH_UPPER_A:CH_UPPER_Z]}) begin
            o_cls.val = RADIX_W'(ch & LETTER_MASK) + LETTER_BIAS;
        end else begin
            o_cls.val = NOT_DIGIT;
        end
        o_cls.is_minus = (ch == CH_MINUS);
        o_cls.is_plus  = (ch == CH_PLUS);
        o_cls.is_hash  = (ch == CH_HASH);
        o_cls.is_zero  = (ch == CH_ZERO);
        o_cls.is_x     = (ch == CH_LOWER_X) || (ch == CH_UPPER_X);
        o_cls.last     = i_in.last;
    end
endmodule

FILE: design/rti_queue.sv
// ----------------------------------------------------------------------------
// rti_queue
// Short queue of classified characters between the front and the back.
// ----------------------------------------------------------------------------
module rti_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rti_pkg::t_cls i_cls,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output rti_pkg::t_cls o_cls
);
    import rti_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(Q_DEPTH);

    t_cls             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W-1:0] r_wr;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_rd;
    logic [PTR_W-1:0] n_wr;

    assign o_ready = (r_cnt != FULL);
    assign o_valid = (r_cnt != '0);
    assign o_cls   = r_mem[r_rd];

    always_comb begin
        n_rd = (r_rd == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        n_wr = (r_wr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

FILE: design/rti_back.sv
// ----------------------------------------------------------------------------
// rti_back
// Parse sequencer: sign and prefix handling, checked multiply-add of digits,
// and the registered result stage.
// ----------------------------------------------------------------------------
module rti_back #(
    parameter int WORD_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [rti_pkg::RADIX_W-1:0] i_radix,
    input  logic                        i_decode,
    input  logic                        i_valid,
    input  rti_pkg::t_cls               i_cls,
    output logic                        o_pop,
    rti_out_if.source                   o_out
);
    import rti_pkg::*;

    localparam int PROD_W = WORD_BITS + RADIX_W;

    typedef enum logic [4:0] {
        PH_START     = 5'b00001,
        PH_BODY      = 5'b00010,
        PH_AFTERSIGN = 5'b00100,
        PH_SAWZERO   = 5'b01000,
        PH_BODYFIRST = 5'b10000
    } t_phase;

    t_phase                 r_phase;
    t_phase                 n_phase;
    logic [WORD_BITS-1:0]   r_accum;
    logic [WORD_BITS-1:0]   n_accum;
    logic                   r_neg;
    logic                   n_neg;
    logic [RADIX_W-1:0]     r_act;
    logic [RADIX_W-1:0]     n_act;
    logic                   r_got;
    logic                   n_got;
    logic                   r_failed;
    logic                   n_failed;

    logic                   r_out_valid;
    logic [WORD_BITS-1:0]   r_out_value;
    logic                   r_out_error;

    logic [RADIX_W-1:0]     dr;
    logic                   take;
    logic                   prefix;
    logic                   is_sign;
    logic                   bad;
    logic                   ovf;
    logic [WORD_BITS-1:0]   lim;
    logic [PROD_W-1:0]      prod;
    logic                   res_error;
    logic [WORD_BITS-1:0]   res_value;

    assign is_sign = i_cls.is_minus | i_cls.is_plus;
    assign o_pop   = i_valid && (!i_cls.last || !r_out_valid || o_out.ready);

    always_comb begin
        n_accum  = r_accum;
        n_neg    = r_neg;
        n_phase  = r_phase;
        n_act    = r_act;
        n_got    = r_got;
        n_failed = r_failed;
        dr       = r_act;
        take     = 1'b0;
        prefix   = 1'b0;

        case (r_phase)
            PH_START: begin
                if (i_decode) begin
                    if (is_sign) begin
                        n_neg   = i_cls.is_minus;
                        n_phase = PH_AFTERSIGN;
                    end else begin
                        prefix = 1'b1;
                    end
                end else begin
                    dr      = i_radix;
                    n_act   = i_radix;
                    n_phase = PH_BODY;
                    if (!(i_radix inside {[RADIX_MIN:RADIX_MAX]})) begin
                        n_failed = 1'b1;
                    end
                    if (i_cls.is_minus) begin
                        n_neg = 1'b1;
                    end else begin
                        take = 1'b1;
                    end
                end
            end
            PH_AFTERSIGN: begin
                prefix = 1'b1;
            end
            PH_SAWZERO: begin
                if (i_cls.is_x) begin
                    n_act   = RADIX_HEX;
                    n_got   = 1'b0;
                    n_phase = PH_BODYFIRST;
                end else begin
                    n_act   = RADIX_OCT;
                    dr      = RADIX_OCT;
                    n_phase = PH_BODY;
                    if (is_sign) begin
                        n_failed = 1'b1;
                    end else begin
                        take = 1'b1;
                    end
                end
            end
            PH_BODYFIRST: begin
                n_phase = PH_BODY;
                if (is_sign) begin
                    n_failed = 1'b1;
                end else begin
                    take = 1'b1;
                end
            end
            default: begin
                n_phase = PH_BODY;
                take    = 1'b1;
            end
        endcase

        if (prefix) begin
            if (i_cls.is_hash) begin
                n_act   = RADIX_HEX;
                n_phase = PH_BODYFIRST;
            end else if (i_cls.is_zero) begin
                n_act   = RADIX_DEC;
                n_accum = '0;
                n_got   = 1'b1;
                n_phase = PH_SAWZERO;
            end else if (is_sign) begin
                n_failed = 1'b1;
                n_phase  = PH_BODY;
            end else begin
                n_act   = RADIX_DEC;
                dr      = RADIX_DEC;
                n_phase = PH_BODY;
                take    = 1'b1;
            end
        end

        lim  = {1'b1, {(WORD_BITS - 1){1'b0}}} - WORD_BITS'(!r_neg);
        prod = PROD_W'(r_accum) * PROD_W'(dr) + PROD_W'(i_cls.val);
        bad  = !(dr inside {[RADIX_MIN:RADIX_MAX]}) || (i_cls.val >= dr);
        ovf  = prod > PROD_W'(lim);

        if (take && !r_failed) begin
            if (bad || ovf) begin
                n_failed = 1'b1;
            end else begin
                n_accum = prod[WORD_BITS-1:0];
                n_got   = 1'b1;
            end
        end

        res_error = n_failed | ~n_got;
        if (res_error) begin
            res_value = '0;
        end else if (n_neg) begin
            res_value = '0 - n_accum;
        end else begin
            res_value = n_accum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_accum  <= '0;
            r_neg    <= 1'b0;
            r_act    <= RADIX_DEC;
            r_got    <= 1'b0;
            r_failed <= 1'b0;
        end else if (o_pop) begin
            r_act <= n_act;
            if (i_cls.last) begin
                r_phase  <= PH_START;
                r_accum  <= '0;
                r_neg    <= 1'b0;
                r_got    <= 1'b0;
                r_failed <= 1'b0;
            end else begin
                r_phase  <= n_phase;
                r_accum  <= n_accum;
                r_neg    <= n_neg;
                r_got    <= n_got;
                r_failed <= n_failed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_cls.last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cls.last) begin
            r_out_value <= res_value;
            r_out_error <= res_error;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.value = r_out_value;
    assign o_out.error = r_out_error;
endmodule

FILE: design/radix_text_to_integer_top.sv
// ----------------------------------------------------------------------------
// radix_text_to_integer_top
// Parses a signed integer from a character stream, one character per transfer.
//
//   Channel  Dir  Payload              Transfer
//   i_in     in   ch[7:0], last        valid & ready
//   o_out    out  value[W-1:0], error  valid & ready, one per last character
//   i_cfg    in   idx, data[5:0]       i_cfg_we
//
// One character per cycle unless a last character waits on a stalled output,
// set by the single multiply-add and bound compare in the back end. A last
// character passes through the two-entry queue; its result is registered as it
// is popped from the queue head and held until it transfers out.
// Reset clears the parse state, sets the radix to ten and plain mode.
// A stalled output holds its result; the queue takes characters until it fills.
// ----------------------------------------------------------------------------
`include "radix_text_to_integer_top_macros.svh"

module radix_text_to_integer_top #(
    parameter int WORD_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    rti_in_if.sink                           i_in,
    rti_out_if.source                        o_out,
    input  logic                             i_cfg_we,
    input  logic [rti_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [rti_pkg::RADIX_W-1:0]      i_cfg_data
);
    import rti_pkg::*;

    logic [RADIX_W-1:0] r_radix;
    logic               r_decode;
    logic               q_push;
    logic               q_ready;
    logic               q_pop;
    logic               q_valid;
    t_cls               front_cls;
    t_cls               q_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix  <= RADIX_DEC;
            r_decode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RADIX:  r_radix  <= i_cfg_data;
                CFG_DECODE: r_decode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    rti_front u_front (
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_push    (q_push),
        .o_cls     (front_cls)
    );

    rti_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cls   (front_cls),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cls   (q_head)
    );

    rti_back #(
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_radix  (r_radix),
        .i_decode (r_decode),
        .i_valid  (q_valid),
        .i_cls    (q_head),
        .o_pop    (q_pop),
        .o_out    (o_out)
    );

    `RTI_ASSERT_NOW(a_error_zero, i_clk, i_rst_n, o_out.valid && o_out.error, o_out.value == '0, "error result with nonzero value")
    `RTI_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, q_pop && q_head.last, !o_out.valid || o_out.ready, "result overwritten")
    `RTI_ASSERT_NEXT(a_result_lands, i_clk, i_rst_n, q_pop && q_head.last, o_out.valid, "finished string gave no result")
endmodule
